// File: hw/rtl/shfc_pkg.sv
// Package for the sync header frame deframer with CRC-32 check.
// Holds frame geometry, the CRC-32 byte update and the result record.
// No dependencies.
package shfc_pkg;

    localparam int FRAME_BYTES = 72;
    localparam int CRC_BYTES = FRAME_BYTES - 4;
    localparam int POS_W = 7;
    localparam logic [7:0] SYNC_RESET = 8'h5A;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    typedef logic [7:0] byte_t;
    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        byte_t data;
        logic  in_frame;
        pos_t  frame_pos;
        logic  frame_end;
        logic  crc_ok;
    } result_t;

    // Reflected CRC-32 update over one byte.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input byte_t b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/shfc_if.sv
// Channel interfaces of the deframer: received bytes, results and configuration.
// Depends on shfc_pkg.
interface shfc_rx_if;
    import shfc_pkg::*;
    logic  valid;
    logic  ready;
    byte_t rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface shfc_res_if;
    import shfc_pkg::*;
    logic  valid;
    logic  ready;
    byte_t data;
    logic  in_frame;
    pos_t  frame_pos;
    logic  frame_end;
    logic  crc_ok;
    modport source (output valid, output data, output in_frame, output frame_pos,
                    output frame_end, output crc_ok, input ready);
    modport sink (input valid, input data, input in_frame, input frame_pos,
                  input frame_end, input crc_ok, output ready);
endinterface

interface shfc_cfg_if;
    import shfc_pkg::*;
    logic  valid;
    logic  ready;
    byte_t sync_byte;
    modport source (output valid, output sync_byte, input ready);
    modport sink (input valid, input sync_byte, output ready);
endinterface

// File: hw/rtl/shfc_deframer.sv
// Sync hunt, frame position tracking and CRC-32 accumulation for one byte per cycle while accept is high.
// Holds the sync byte register; depends on shfc_pkg.
module shfc_deframer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  shfc_pkg::byte_t   cfg_sync,
    input  logic              accept,
    input  shfc_pkg::byte_t   rx_byte,
    output shfc_pkg::result_t result
);
    import shfc_pkg::*;

    byte_t       sync_byte_reg;
    logic [31:0] crc_sync1_reg;
    logic        sync_count_reg, sync_count_next;
    logic        collecting_reg, collecting_next;
    pos_t        byte_count_reg, byte_count_next;
    logic [31:0] running_crc_reg, running_crc_next;
    logic [31:0] received_crc_reg, received_crc_next;
    logic [1:0]  lane;

    // The CRC after the first sync byte is kept with the sync byte itself.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg <= SYNC_RESET;
            crc_sync1_reg <= crc32_byte(CRC_INIT, SYNC_RESET);
        end
        else if (cfg_we)
        begin
            sync_byte_reg <= cfg_sync;
            crc_sync1_reg <= crc32_byte(CRC_INIT, cfg_sync);
        end
    end

    assign lane = 2'(byte_count_reg - POS_W'(CRC_BYTES));

    always_comb
    begin
        sync_count_next   = sync_count_reg;
        collecting_next   = collecting_reg;
        byte_count_next   = byte_count_reg;
        running_crc_next  = running_crc_reg;
        received_crc_next = received_crc_reg;
        result.data       = rx_byte;
        result.in_frame   = 1'b0;
        result.frame_pos  = '0;
        result.frame_end  = 1'b0;
        result.crc_ok     = 1'b0;
        if (!collecting_reg)
        begin
            if (rx_byte == sync_byte_reg)
            begin
                if (!sync_count_reg)
                begin
                    sync_count_next = 1'b1;
                end
                else
                begin
                    sync_count_next   = 1'b0;
                    collecting_next   = 1'b1;
                    result.in_frame   = 1'b1;
                    result.frame_pos  = POS_W'(1);
                    running_crc_next  = crc32_byte(crc_sync1_reg, rx_byte);
                    received_crc_next = '0;
                    byte_count_next   = POS_W'(2);
                end
            end
            else
            begin
                sync_count_next = 1'b0;
            end
        end
        else
        begin
            result.in_frame  = 1'b1;
            result.frame_pos = byte_count_reg;
            if (byte_count_reg < POS_W'(CRC_BYTES))
            begin
                running_crc_next = crc32_byte(running_crc_reg, rx_byte);
            end
            else
            begin
                received_crc_next = received_crc_reg | ({24'd0, rx_byte} << {lane, 3'b000});
            end
            byte_count_next = byte_count_reg + POS_W'(1);
            if (byte_count_reg == POS_W'(FRAME_BYTES - 1))
            begin
                result.frame_end = 1'b1;
                result.crc_ok    = ((running_crc_next ^ CRC_INIT) == received_crc_next);
                collecting_next  = 1'b0;
                sync_count_next  = 1'b0;
                byte_count_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_count_reg   <= 1'b0;
            collecting_reg   <= 1'b0;
            byte_count_reg   <= '0;
            running_crc_reg  <= CRC_INIT;
            received_crc_reg <= '0;
        end
        else if (accept)
        begin
            sync_count_reg   <= sync_count_next;
            collecting_reg   <= collecting_next;
            byte_count_reg   <= byte_count_next;
            running_crc_reg  <= running_crc_next;
            received_crc_reg <= received_crc_next;
        end
    end

endmodule

// File: hw/rtl/shfc_out_reg.sv
// Result register with valid flag; it loads whenever it is empty or being drained.
// Depends on shfc_pkg.
module shfc_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  shfc_pkg::result_t in_result,
    output logic              out_valid,
    input  logic              out_ready,
    output shfc_pkg::result_t out_result
);
    import shfc_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            result_reg <= in_result;
        end
    end

endmodule

// File: hw/rtl/sync_header_frame_crc32_check_top.sv
// Top level of the sync header deframer with CRC-32 frame check.
// Depends on shfc_pkg, shfc_if, shfc_deframer and shfc_out_reg.
//
//   Channel | Direction | Payload
//   rx      | in        | rx_byte
//   res     | out       | data, in_frame, frame_pos, frame_end, crc_ok
//   cfg     | in        | sync_byte
//
// Every byte request yields one result request in the cycle after it is accepted.
// One byte is accepted per cycle while the output register can load; the byte-wide CRC update is the longest path.
// A result that is not taken holds in the output register and stops new bytes.
// Reset puts the block in hunt mode with sync byte 0x5A; cfg is always ready.
module sync_header_frame_crc32_check_top
(
    input  logic        clk,
    input  logic        rst_n,
    shfc_rx_if.sink     rx,
    shfc_res_if.source  res,
    shfc_cfg_if.sink    cfg
);
    import shfc_pkg::*;

    logic    accept;
    logic    rx_ready;
    result_t step_result;
    result_t out_result;

    assign cfg.ready = 1'b1;
    assign rx.ready  = rx_ready;
    assign accept    = rx.valid && rx_ready;

    shfc_deframer u_deframer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg.valid),
        .cfg_sync (cfg.sync_byte),
        .accept   (accept),
        .rx_byte  (rx.rx_byte),
        .result   (step_result)
    );

    shfc_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx.valid),
        .in_ready   (rx_ready),
        .in_result  (step_result),
        .out_valid  (res.valid),
        .out_ready  (res.ready),
        .out_result (out_result)
    );

    assign res.data      = out_result.data;
    assign res.in_frame  = out_result.in_frame;
    assign res.frame_pos = out_result.frame_pos;
    assign res.frame_end = out_result.frame_end;
    assign res.crc_ok    = out_result.crc_ok;

endmodule
